@@ sv/sdpa_pkg.sv @@
package sdpa_pkg;

   localparam int unsigned DefaultTableDepth = 256;

   localparam logic [1:0] ACT_READ  = 2'd0;
   localparam logic [1:0] ACT_WRITE = 2'd1;
   localparam logic [1:0] ACT_LOAD  = 2'd2;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_NOTFOUND = 3'd1;
   localparam logic [2:0] ST_RDONLY   = 3'd2;
   localparam logic [2:0] ST_ABOVE    = 3'd3;
   localparam logic [2:0] ST_BELOW    = 3'd4;

   localparam logic [7:0] CMD_UP16 = 8'h4B;
   localparam logic [7:0] CMD_UP32 = 8'h43;
   localparam logic [3:0] LEN_16   = 4'd6;
   localparam logic [3:0] LEN_32   = 4'd8;

   localparam int unsigned AttrLong   = 0;
   localparam int unsigned AttrSigned = 1;
   localparam int unsigned AttrRdonly = 2;
   localparam int unsigned AttrReboot = 3;
   localparam int unsigned AttrEeprom = 4;

   localparam logic CSR_ENTRIES = 1'b0;
   localparam logic CSR_SAVE    = 1'b1;

   typedef struct packed {
      logic [1:0]  action;
      logic [3:0]  index_nibble;
      logic [7:0]  sub_index;
      logic [31:0] data_value;
      logic [7:0]  slot;
      logic [11:0] param_number;
      logic [15:0] upper_limit;
      logic [15:0] lower_limit;
      logic [4:0]  attributes;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  found_slot;
      logic [7:0]  response_command;
      logic [31:0] read_value;
      logic [3:0]  frame_length;
      logic        save_request;
      logic        reboot_warning;
   } rsp_type;

endpackage

@@ sv/sdo_parameter_dictionary_access_top.sv @@
// Parameter dictionary with expedited SDO-style access. Requests enter through a
// two-deep queue and are then carried out one at a time by an engine that owns the
// parameter table (key, value, limits and attributes, one memory each). The engine
// takes a request from the queue whenever it is idle. A load writes its slot in
// every memory as it is taken. A read or write binary-searches the first
// entries_in_use slots (at most TABLE_DEPTH) with one registered memory probe per
// step (S_WAIT, then S_CMP); a hit then reads the low and high words, and a write
// checks the limits and writes the low word and, for a long value, the high word.
// A full table of 256 entries needs at most nine probes. The result is copied into
// an output register and held there until popped; while it waits, the engine may
// finish the next request and then holds it, and the queue keeps accepting
// requests until two are waiting. Slots must be loaded, sorted by key, before
// they are searched; the table holds no valid bits and a never-loaded slot
// reads as anything.
module sdo_parameter_dictionary_access_top #(
   parameter int unsigned TABLE_DEPTH = sdpa_pkg::DefaultTableDepth
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  sdpa_pkg::req_type req_data,
   output logic              req_full,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output sdpa_pkg::rsp_type rsp_data,
   input  logic              csr_write,
   input  logic              csr_index,
   input  logic [8:0]        csr_data
);
   import sdpa_pkg::*;

   logic [8:0] entries_ff;
   logic       save_ff;
   logic       q_empty, q_pop, rsp_valid;
   req_type    q_data;

   // Configuration registers; the user must write them only while the block is idle, the block does not enforce it.
   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= '0;
         save_ff    <= 1'b0;
      end else if (csr_write) begin
         if (csr_index == CSR_ENTRIES) begin
            entries_ff <= csr_data;
         end else begin
            save_ff <= csr_data[0];
         end
      end
   end

   sdpa_fifo u_fifo (
      .clock, .reset,
      .push(req_push), .push_data(req_data), .full(req_full),
      .pop(q_pop), .pop_data(q_data), .empty(q_empty)
   );

   sdpa_engine #(.TABLE_DEPTH(TABLE_DEPTH)) u_engine (
      .clock, .reset,
      .entries_in_use(entries_ff), .save_enable(save_ff),
      .cmd_valid(!q_empty), .cmd(q_data), .cmd_pop(q_pop),
      .rsp_valid(rsp_valid), .rsp(rsp_data), .rsp_taken(rsp_pop)
   );

   assign rsp_empty = !rsp_valid;
endmodule

@@ sv/sdpa_fifo.sv @@
module sdpa_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  sdpa_pkg::req_type  push_data,
   output logic               full,
   input  logic               pop,
   output sdpa_pkg::req_type  pop_data,
   output logic               empty
);
   import sdpa_pkg::*;

   req_type    slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   assign full     = count_ff == 2'd2;
   assign empty    = count_ff == 2'd0;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push && !full) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push && !full) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop && !empty) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(push && !full) - 2'(pop && !empty);
      end
   end
endmodule

@@ sv/sdpa_engine.sv @@
module sdpa_engine #(
   parameter int unsigned TABLE_DEPTH = sdpa_pkg::DefaultTableDepth
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [8:0]        entries_in_use,
   input  logic              save_enable,
   input  logic              cmd_valid,
   input  sdpa_pkg::req_type cmd,
   output logic              cmd_pop,
   output logic              rsp_valid,
   output sdpa_pkg::rsp_type rsp,
   input  logic              rsp_taken
);
   import sdpa_pkg::*;

   localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned BW = AW + 2;
   localparam logic [BW-1:0] DepthB = BW'(TABLE_DEPTH);

   typedef enum logic [9:0] {
      S_IDLE   = 10'b0000000001,
      S_PROBE  = 10'b0000000010,
      S_WAIT   = 10'b0000000100,
      S_CMP    = 10'b0000001000,
      S_RDLO   = 10'b0000010000,
      S_RDHI   = 10'b0000100000,
      S_CHECK  = 10'b0001000000,
      S_WRHI   = 10'b0010000000,
      S_RESULT = 10'b0100000000,
      S_HOLD   = 10'b1000000000
   } state_type;

   logic [11:0] key_mem [TABLE_DEPTH];
   logic [15:0] val_mem [TABLE_DEPTH];
   logic [15:0] up_mem  [TABLE_DEPTH];
   logic [15:0] lo_mem  [TABLE_DEPTH];
   logic [4:0]  att_mem [TABLE_DEPTH];

   state_type       state_ff;
   req_type         cur_ff;
   logic [BW-1:0]   lo_ff, hi_ff, mid_ff;
   logic [AW-1:0]   m_ff;
   logic [AW-1:0]   rd_addr;
   logic [11:0]     key_rd_ff;
   logic [15:0]     val_rd_ff, up_rd_ff, lo_rd_ff;
   logic [4:0]      att_rd_ff;
   logic [15:0]     val_lo_ff, up_lo_ff, lo_lo_ff;
   logic [4:0]      att_ff;
   logic            hi_ok_ff;
   rsp_type         rsp_ff;
   rsp_type         out_ff;
   logic            rsp_valid_ff;

   logic [11:0] key;
   logic [BW-1:0] n_clip;
   logic [31:0] vmax, vmin, old_val, new_val;
   logic        above, below;
   logic        mem_we;
   logic [AW-1:0] mem_wa;
   logic [15:0] wr_val;

   assign key     = {cur_ff.index_nibble, cur_ff.sub_index};
   assign n_clip  = (13'(entries_in_use) > 13'(TABLE_DEPTH)) ? DepthB
                    : BW'(entries_in_use);
   assign cmd_pop = state_ff == S_IDLE && cmd_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = out_ff;

   // Memory read address per state; the high slot stays addressed from the
   // cycle after a match through S_RDLO, S_RDHI, S_CHECK and S_WRHI.
   always_comb begin
      rd_addr = mid_ff[AW-1:0];
      if (state_ff == S_RDLO || state_ff == S_RDHI || state_ff == S_CHECK
          || state_ff == S_WRHI) begin
         rd_addr = AW'(m_ff + AW'(1));
      end
   end

   // Range check on the assembled limits, and the old and new values for the save request.
   always_comb begin
      if (att_ff[AttrLong]) begin
         vmax = {hi_ok_ff ? up_rd_ff : 16'h0, up_lo_ff};
         vmin = {hi_ok_ff ? lo_rd_ff : 16'h0, lo_lo_ff};
      end else if (att_ff[AttrSigned]) begin
         vmax = {{16{up_lo_ff[15]}}, up_lo_ff};
         vmin = {{16{lo_lo_ff[15]}}, lo_lo_ff};
      end else begin
         vmax = {16'h0, up_lo_ff};
         vmin = {16'h0, lo_lo_ff};
      end
      if (att_ff[AttrSigned]) begin
         above = $signed(cur_ff.data_value) > $signed(vmax);
         below = $signed(cur_ff.data_value) < $signed(vmin);
      end else begin
         above = cur_ff.data_value > vmax;
         below = cur_ff.data_value < vmin;
      end
      old_val = {(att_ff[AttrLong] && hi_ok_ff) ? val_rd_ff : 16'h0, val_lo_ff};
      new_val = att_ff[AttrLong] ? cur_ff.data_value
                : {16'h0, cur_ff.data_value[15:0]};
   end

   // Single write port: loads, low word and high word of value writes.
   always_comb begin
      mem_we = 1'b0;
      mem_wa = m_ff;
      wr_val = cur_ff.data_value[15:0];
      if (state_ff == S_CHECK && !above && !below) begin
         mem_we = 1'b1;
      end else if (state_ff == S_WRHI) begin
         mem_we = 1'b1;
         mem_wa = AW'(m_ff + AW'(1));
         wr_val = cur_ff.data_value[31:16];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && cmd_valid && cmd.action == ACT_LOAD
          && {1'b0, cmd.slot} < 9'(TABLE_DEPTH > 511 ? 511 : TABLE_DEPTH)
          || (state_ff == S_IDLE && cmd_valid && cmd.action == ACT_LOAD
              && TABLE_DEPTH > 256)) begin
         key_mem[AW'(cmd.slot)] <= cmd.param_number;
         val_mem[AW'(cmd.slot)] <= cmd.data_value[15:0];
         up_mem[AW'(cmd.slot)]  <= cmd.upper_limit;
         lo_mem[AW'(cmd.slot)]  <= cmd.lower_limit;
         att_mem[AW'(cmd.slot)] <= cmd.attributes;
      end else if (mem_we) begin
         val_mem[mem_wa] <= wr_val;
      end
      key_rd_ff <= key_mem[rd_addr];
      val_rd_ff <= val_mem[rd_addr];
      up_rd_ff  <= up_mem[rd_addr];
      lo_rd_ff  <= lo_mem[rd_addr];
      att_rd_ff <= att_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (cmd_valid) begin
                  cur_ff <= cmd;
                  rsp_ff <= '0;
                  lo_ff  <= '0;
                  state_ff <= (cmd.action == ACT_READ || cmd.action == ACT_WRITE)
                              ? S_PROBE : S_RESULT;
               end
            end
            S_PROBE: begin
               if (n_clip == '0) begin
                  rsp_ff.status <= ST_NOTFOUND;
                  state_ff <= S_RESULT;
               end else begin
                  hi_ff <= n_clip - BW'(1);
                  mid_ff <= (n_clip - BW'(1)) >> 1;
                  state_ff <= S_WAIT;
               end
            end
            S_WAIT: begin
               // The memories are read at mid_ff at the end of this cycle.
               state_ff <= S_CMP;
            end
            S_CMP: begin
               // data for mid_ff arrives this cycle
               if (key == key_rd_ff) begin
                  m_ff     <= mid_ff[AW-1:0];
                  att_ff   <= att_rd_ff;
                  val_lo_ff <= val_rd_ff;
                  up_lo_ff <= up_rd_ff;
                  lo_lo_ff <= lo_rd_ff;
                  rsp_ff.found_slot <= 8'(mid_ff);
                  state_ff <= S_RDLO;
               end else begin
                  logic [BW-1:0] nlo, nhi;
                  nlo = lo_ff;
                  nhi = hi_ff;
                  if (key < key_rd_ff) begin
                     nhi = mid_ff - BW'(1);
                  end else begin
                     nlo = mid_ff + BW'(1);
                  end
                  lo_ff <= nlo;
                  hi_ff <= nhi;
                  if (mid_ff == '0 && key < key_rd_ff || nlo > nhi) begin
                     rsp_ff.status <= ST_NOTFOUND;
                     state_ff <= S_RESULT;
                  end else begin
                     mid_ff <= (nlo + nhi) >> 1;
                     state_ff <= S_WAIT;
                  end
               end
            end
            S_RDLO: begin
               hi_ok_ff <= BW'(m_ff) + BW'(1) < DepthB;
               state_ff <= S_RDHI;
            end
            S_RDHI: begin
               if (cur_ff.action == ACT_READ) begin
                  rsp_ff.response_command <= att_ff[AttrLong] ? CMD_UP32 : CMD_UP16;
                  rsp_ff.frame_length     <= att_ff[AttrLong] ? LEN_32 : LEN_16;
                  rsp_ff.read_value <= {(att_ff[AttrLong] && hi_ok_ff) ? val_rd_ff
                                        : 16'h0, val_lo_ff};
                  state_ff <= S_RESULT;
               end else if (att_ff[AttrRdonly]) begin
                  rsp_ff.status <= ST_RDONLY;
                  state_ff <= S_RESULT;
               end else begin
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               if (above) begin
                  rsp_ff.status <= ST_ABOVE;
                  state_ff <= S_RESULT;
               end else if (below) begin
                  rsp_ff.status <= ST_BELOW;
                  state_ff <= S_RESULT;
               end else begin
                  rsp_ff.save_request <= save_enable && att_ff[AttrEeprom]
                                         && old_val != new_val;
                  rsp_ff.reboot_warning <= att_ff[AttrReboot];
                  state_ff <= (att_ff[AttrLong] && hi_ok_ff) ? S_WRHI : S_RESULT;
               end
            end
            S_WRHI: begin
               state_ff <= S_RESULT;
            end
            S_RESULT: begin
               if (!rsp_valid_ff || rsp_taken) begin
                  out_ff       <= rsp_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  state_ff <= S_HOLD;
               end
            end
            S_HOLD: begin
               if (rsp_taken) begin
                  out_ff       <= rsp_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
         if (rsp_taken && rsp_valid_ff && state_ff != S_RESULT && state_ff != S_HOLD) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end
endmodule
